// ===== src/rwcp_pkg.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser package
// Shared types and constants for the parser front end, result queue and
// result sequencer.
// ----------------------------------------------------------------------------
package rwcp_pkg;

  typedef enum logic [2:0] {
    PH_FILE_HEADER  = 3'd0,
    PH_CHUNK_HEADER = 3'd1,
    PH_BODY         = 3'd2,
    PH_PAD          = 3'd3,
    PH_DEAD         = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_FMT   = 2'd1,
    CLS_DATA  = 2'd2
  } chunk_class_e;

  localparam logic [1:0] KindPcm     = 2'd0;
  localparam logic [1:0] KindMarker  = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusBadHeader = 3'd1;
  localparam logic [2:0] StatusNoFmt     = 3'd2;
  localparam logic [2:0] StatusNoData    = 3'd3;
  localparam logic [2:0] StatusNeither   = 3'd4;

  localparam logic [3:0][7:0] RiffTag = {8'h46, 8'h46, 8'h49, 8'h52};
  localparam logic [3:0][7:0] WaveTag = {8'h45, 8'h56, 8'h41, 8'h57};
  localparam logic [31:0]     TagFmt  = 32'h2074_6D66;
  localparam logic [31:0]     TagData = 32'h6174_6164;

  localparam logic [31:0] FmtMinLen   = 32'd16;
  localparam logic [31:0] FileHdrLen  = 32'd12;
  localparam logic [31:0] ChunkHdrLen = 32'd8;

  typedef struct packed {
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
  } format_t;

  typedef struct packed {
    logic       first_valid;
    logic       first_is_marker;
    logic [7:0] pcm_byte;
    logic       summary;
    logic [2:0] status;
    format_t    format;
  } event_t;

endpackage

// ===== src/rwcp_front.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE parser front end
// Walks the file header and chunks one byte per cycle while accept_i is high
// and posts an event for every byte that causes results.
// ----------------------------------------------------------------------------
module rwcp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        file_byte_i,
  input  logic              end_of_file_i,
  output logic              ev_valid_o,
  output rwcp_pkg::event_t  ev_o
);

  rwcp_pkg::phase_e       phase_q, phase_d;
  rwcp_pkg::chunk_class_e cls_q, cls_d;
  logic [31:0]            cnt_q, cnt_d;
  logic [31:0]            tag_q, tag_d;
  logic [31:0]            len_q, len_d;
  logic                   hok_q, hok_d;
  logic [15:0][7:0]       pend_q, pend_d;
  logic [15:0][7:0]       comm_q, comm_d;
  logic                   fseen_q, fseen_d;
  logic                   dseen_q, dseen_d;
  logic                   done;
  rwcp_pkg::event_t       ev;

  always_comb begin
    phase_d = phase_q;
    cls_d   = cls_q;
    cnt_d   = cnt_q;
    tag_d   = tag_q;
    len_d   = len_q;
    hok_d   = hok_q;
    pend_d  = pend_q;
    comm_d  = comm_q;
    fseen_d = fseen_q;
    dseen_d = dseen_q;
    done    = 1'b0;
    ev      = '0;

    case (phase_q)
      rwcp_pkg::PH_FILE_HEADER: begin
        if (cnt_q < 32'd4) begin
          if (file_byte_i != rwcp_pkg::RiffTag[cnt_q[1:0]]) hok_d = 1'b0;
        end else if (cnt_q >= 32'd8 && cnt_q < rwcp_pkg::FileHdrLen) begin
          if (file_byte_i != rwcp_pkg::WaveTag[cnt_q[1:0]]) hok_d = 1'b0;
        end
        cnt_d = cnt_q + 32'd1;
        if (cnt_d >= rwcp_pkg::FileHdrLen) begin
          cnt_d   = '0;
          phase_d = hok_d ? rwcp_pkg::PH_CHUNK_HEADER : rwcp_pkg::PH_DEAD;
        end
      end
      rwcp_pkg::PH_CHUNK_HEADER: begin
        if (cnt_q < 32'd4) begin
          tag_d = {file_byte_i, tag_q[31:8]};
        end else begin
          len_d = {file_byte_i, len_q[31:8]};
        end
        cnt_d = cnt_q + 32'd1;
        if (cnt_d >= rwcp_pkg::ChunkHdrLen) begin
          if (tag_d == rwcp_pkg::TagFmt && len_d >= rwcp_pkg::FmtMinLen) begin
            cls_d = rwcp_pkg::CLS_FMT;
          end else if (tag_d == rwcp_pkg::TagData) begin
            cls_d              = rwcp_pkg::CLS_DATA;
            ev.first_valid     = 1'b1;
            ev.first_is_marker = 1'b1;
          end else begin
            cls_d = rwcp_pkg::CLS_OTHER;
          end
          cnt_d   = '0;
          phase_d = rwcp_pkg::PH_BODY;
          if (len_d == 32'd0) done = 1'b1;
        end
      end
      rwcp_pkg::PH_BODY: begin
        if (cls_q == rwcp_pkg::CLS_FMT && cnt_q < rwcp_pkg::FmtMinLen) begin
          pend_d[cnt_q[3:0]] = file_byte_i;
        end else if (cls_q == rwcp_pkg::CLS_DATA) begin
          ev.first_valid = 1'b1;
          ev.pcm_byte    = file_byte_i;
        end
        cnt_d = cnt_q + 32'd1;
        if (cnt_d == len_q) done = 1'b1;
      end
      rwcp_pkg::PH_PAD: begin
        phase_d = rwcp_pkg::PH_CHUNK_HEADER;
        cnt_d   = '0;
      end
      default: begin
      end
    endcase

    if (done) begin
      if (cls_d == rwcp_pkg::CLS_FMT) begin
        comm_d  = pend_d;
        fseen_d = 1'b1;
      end else if (cls_d == rwcp_pkg::CLS_DATA) begin
        dseen_d = 1'b1;
      end
      phase_d = len_d[0] ? rwcp_pkg::PH_PAD : rwcp_pkg::PH_CHUNK_HEADER;
      cnt_d   = '0;
    end

    if (phase_d == rwcp_pkg::PH_CHUNK_HEADER && cnt_d == 32'd0) begin
      tag_d = '0;
      len_d = '0;
    end

    if (end_of_file_i) begin
      ev.summary = 1'b1;
      if (phase_d == rwcp_pkg::PH_FILE_HEADER || phase_d == rwcp_pkg::PH_DEAD) begin
        ev.status = rwcp_pkg::StatusBadHeader;
      end else if (!fseen_d && !dseen_d) begin
        ev.status = rwcp_pkg::StatusNeither;
      end else if (!fseen_d) begin
        ev.status = rwcp_pkg::StatusNoFmt;
      end else if (!dseen_d) begin
        ev.status = rwcp_pkg::StatusNoData;
      end else begin
        ev.status = rwcp_pkg::StatusOk;
      end
      ev.format.format_tag    = {comm_d[1], comm_d[0]};
      ev.format.channel_count = {comm_d[3], comm_d[2]};
      ev.format.sample_rate   = {comm_d[7], comm_d[6], comm_d[5], comm_d[4]};
      ev.format.byte_rate     = {comm_d[11], comm_d[10], comm_d[9], comm_d[8]};
      ev.format.block_align   = {comm_d[13], comm_d[12]};
      ev.format.sample_bits   = {comm_d[15], comm_d[14]};

      phase_d = rwcp_pkg::PH_FILE_HEADER;
      cls_d   = rwcp_pkg::CLS_OTHER;
      cnt_d   = '0;
      tag_d   = '0;
      len_d   = '0;
      hok_d   = 1'b1;
      pend_d  = '0;
      comm_d  = '0;
      fseen_d = 1'b0;
      dseen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rwcp_pkg::PH_FILE_HEADER;
      cls_q   <= rwcp_pkg::CLS_OTHER;
      cnt_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      hok_q   <= 1'b1;
      pend_q  <= '0;
      comm_q  <= '0;
      fseen_q <= 1'b0;
      dseen_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cls_q   <= cls_d;
      cnt_q   <= cnt_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      hok_q   <= hok_d;
      pend_q  <= pend_d;
      comm_q  <= comm_d;
      fseen_q <= fseen_d;
      dseen_q <= dseen_d;
    end
  end

  assign ev_o       = ev;
  assign ev_valid_o = accept_i && (ev.first_valid || ev.summary);

  a_dead_means_bad_header: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rwcp_pkg::PH_DEAD) |-> !hok_q
  ) else $error("Parser is dead without a failed header check.");

endmodule

// ===== src/rwcp_queue.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE parser event queue
// Small register queue that decouples the parser from the result sequencer.
// ----------------------------------------------------------------------------
module rwcp_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  rwcp_pkg::event_t  wr_data_i,
  input  logic              rd_i,
  output rwcp_pkg::event_t  rd_data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rwcp_pkg::event_t mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_count_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt
  ) else $error("Queue count exceeds its depth.");

  a_no_write_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i
  ) else $error("Event written into a full queue.");

endmodule

// ===== src/rwcp_back.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE parser result sequencer
// Expands each queued event into one or two results and hands them out.
// ----------------------------------------------------------------------------
module rwcp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rwcp_pkg::event_t  head_i,
  input  logic              head_valid_i,
  output logic              head_done_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [1:0]        kind_o,
  output logic [7:0]        pcm_byte_o,
  output logic [2:0]        status_o,
  output rwcp_pkg::format_t format_o,
  output logic              last_of_run_o
);

  logic second_q, second_d;
  logic show_first;
  logic take;

  assign empty_o    = !head_valid_i;
  assign take       = pop_i && head_valid_i;
  assign show_first = head_i.first_valid && !second_q;

  always_comb begin
    second_d    = second_q;
    head_done_o = 1'b0;
    if (show_first) begin
      kind_o        = head_i.first_is_marker ? rwcp_pkg::KindMarker : rwcp_pkg::KindPcm;
      pcm_byte_o    = head_i.first_is_marker ? 8'd0 : head_i.pcm_byte;
      status_o      = '0;
      format_o      = '0;
      last_of_run_o = !head_i.summary;
    end else begin
      kind_o        = rwcp_pkg::KindSummary;
      pcm_byte_o    = '0;
      status_o      = head_i.status;
      format_o      = head_i.format;
      last_of_run_o = 1'b1;
    end
    if (take) begin
      if (last_of_run_o) begin
        head_done_o = 1'b1;
        second_d    = 1'b0;
      end else begin
        second_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else begin
      second_q <= second_d;
    end
  end

  a_second_needs_pair: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (head_valid_i && head_i.first_valid && head_i.summary)
  ) else $error("Second result pending without a two-result event.");

endmodule

// ===== src/riff_wave_chunk_parser.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser
// Parses a WAV byte stream and emits data bytes, data chunk markers and a
// per-file summary with status and format.
// ----------------------------------------------------------------------------
// Input side: present file_byte_i and end_of_file_i with push; a byte is
// taken on a clock edge with push high and full low. Result side: while
// empty is low the oldest result sits on the result ports and is taken on
// an edge with pop high.
// Every byte is parsed in the cycle it is accepted; bytes that cause results
// post one event into a QueueDepth-entry queue that registers it; the results
// show up on the ports when it reaches the head. The parser takes one byte
// per cycle while full is low. A byte that causes two results (data marker or
// data byte, then the summary) needs two pops; last_of_run_o marks the final
// result of each byte. When pop is held low the queue fills and full rises;
// bytes that cause no result are still accepted while the queue has room.
// Reset clears the parser to the file header phase and empties the queue.
// After each summary the parser starts over for the next file.
// ----------------------------------------------------------------------------
module riff_wave_chunk_parser #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  pcm_byte_o,
  output logic [2:0]  status_o,
  output logic [15:0] format_tag_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [31:0] byte_rate_o,
  output logic [15:0] block_align_o,
  output logic [15:0] sample_bits_o,
  output logic        last_of_run_o
);

  logic              accept;
  logic              ev_valid;
  rwcp_pkg::event_t  ev;
  rwcp_pkg::event_t  head;
  logic              q_empty;
  logic              head_done;
  rwcp_pkg::format_t fmt;

  assign accept = push && !full;

  rwcp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .file_byte_i   (file_byte_i),
    .end_of_file_i (end_of_file_i),
    .ev_valid_o    (ev_valid),
    .ev_o          (ev)
  );

  rwcp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (ev_valid),
    .wr_data_i (ev),
    .rd_i      (head_done),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  rwcp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (!q_empty),
    .head_done_o   (head_done),
    .pop_i         (pop),
    .empty_o       (empty),
    .kind_o        (kind_o),
    .pcm_byte_o    (pcm_byte_o),
    .status_o      (status_o),
    .format_o      (fmt),
    .last_of_run_o (last_of_run_o)
  );

  assign format_tag_o    = fmt.format_tag;
  assign channel_count_o = fmt.channel_count;
  assign sample_rate_o   = fmt.sample_rate;
  assign byte_rate_o     = fmt.byte_rate;
  assign block_align_o   = fmt.block_align;
  assign sample_bits_o   = fmt.sample_bits;

endmodule
